// ===== rtl/core/sha1_hash_engine_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine assertion macros
// Concurrent assertion helpers shared by the SHA-1 engine RTL.
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
`define SHA1_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("SHA-1 engine check failed");
`define SHA1_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("SHA-1 engine check failed");
`else
`define SHA1_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define SHA1_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/core/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Types and fixed constants of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    typedef logic [31:0] word_t;

    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam word_t H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

// ===== rtl/core/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-serial SHA-1 digest with one shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid / in_ready  data_byte, byte_valid, end_of_message
//  output    out_valid/ out_ready digest_word, word_index, last_word
//
// Message bytes are taken while the engine is idle; every 64th byte starts a
// compression: 80 rounds of the single round unit, then a fold into the
// chaining words. The final request adds the padding bytes, one or two
// compressions and the readout of the five digest words.
// Reset is asynchronous and active low. Input is not taken while a block is
// compressed, padded or the digest is being read out; output stalls hold.
// ----------------------------------------------------------------------------
`include "sha1_hash_engine_macros.svh"

module sha1_hash_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                byte_valid,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_ready,
    output sha1_pkg::word_t     digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);
    import sha1_pkg::*;

    state_t      state_reg, state_next;
    word_t       h_reg [NUM_WORDS];
    word_t       h_next [NUM_WORDS];
    word_t       v_reg [NUM_WORDS];
    word_t       v_next [NUM_WORDS];
    word_t       w_reg [16];
    word_t       w_next [16];
    logic [23:0] acc_reg, acc_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] count_reg, count_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        mark_done_reg, mark_done_next;
    logic        len_ok_reg, len_ok_next;
    logic        pad_pend_reg, pad_pend_next;
    logic        fin_pend_reg, fin_pend_next;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        load_vars;
    logic        fin_block;
    logic [63:0] len_shift;
    logic [7:0]  len_byte;
    word_t       w_new;
    word_t       f_val;
    word_t       k_val;
    word_t       tmp_sum;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'(NUM_WORDS - 1));

    assign len_shift = {count_reg, 3'b000} << {pos_reg[2:0], 3'b000};
    assign len_byte  = len_shift[63:56];
    assign fin_block = mark_done_reg && len_ok_reg;

    always_comb
    begin
        w_new = (round_reg < 7'd16) ? w_reg[0]
              : {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                 w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};
        if (round_reg < 7'd20)
        begin
            f_val = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            k_val = K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = K_1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            k_val = K_2;
        end
        else
        begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = K_3;
        end
        tmp_sum = {v_reg[0][26:0], v_reg[0][31:27]} + f_val + v_reg[4] + k_val + w_new;
    end

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        mark_done_next = mark_done_reg;
        len_ok_next    = len_ok_reg;
        pad_pend_next  = pad_pend_reg;
        fin_pend_next  = fin_pend_reg;
        wr_en          = 1'b0;
        wr_byte        = '0;
        load_vars      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mark_done_next = 1'b0;
                    len_ok_next    = 1'b0;
                    if (byte_valid)
                    begin
                        wr_en      = 1'b1;
                        wr_byte    = data_byte;
                        count_next = count_reg + 61'd1;
                    end
                    if (byte_valid && (pos_reg == 6'd63))
                    begin
                        load_vars     = 1'b1;
                        pad_pend_next = end_of_message;
                        state_next    = S_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                wr_en = 1'b1;
                if (!mark_done_reg)
                begin
                    wr_byte        = PAD_MARK;
                    mark_done_next = 1'b1;
                    len_ok_next    = (pos_reg[5:3] != 3'b111);
                end
                else if (len_ok_reg && (pos_reg[5:3] == 3'b111))
                begin
                    wr_byte = len_byte;
                end
                if (pos_reg == 6'd63)
                begin
                    load_vars     = 1'b1;
                    fin_pend_next = fin_block;
                    pad_pend_next = !fin_block;
                    if (!fin_block)
                    begin
                        len_ok_next = 1'b1;
                    end
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = w_new;
                v_next[4]  = v_reg[3];
                v_next[3]  = v_reg[2];
                v_next[2]  = {v_reg[1][1:0], v_reg[1][31:2]};
                v_next[1]  = v_reg[0];
                v_next[0]  = tmp_sum;
                if (round_reg == 7'(NUM_ROUNDS - 1))
                begin
                    round_next = '0;
                    state_next = S_FOLD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            S_FOLD:
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                if (fin_pend_reg)
                begin
                    state_next = S_OUT;
                end
                else if (pad_pend_reg)
                begin
                    pad_pend_next = 1'b0;
                    state_next    = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == 3'(NUM_WORDS - 1))
                    begin
                        h_next        = H_INIT;
                        count_next    = '0;
                        idx_next      = '0;
                        fin_pend_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en)
        begin
            pos_next = pos_reg + 6'd1;
            if (pos_reg[1:0] == 2'b11)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = {acc_reg, wr_byte};
            end
            else
            begin
                acc_next = {acc_reg[15:0], wr_byte};
            end
        end

        if (load_vars)
        begin
            v_next = h_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            h_reg         <= H_INIT;
            pos_reg       <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            mark_done_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            pad_pend_reg  <= 1'b0;
            fin_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            mark_done_reg <= mark_done_next;
            len_ok_reg    <= len_ok_next;
            pad_pend_reg  <= pad_pend_next;
            fin_pend_reg  <= fin_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        w_reg   <= w_next;
        acc_reg <= acc_next;
    end

    `SHA1_ASSERT_SAME(a_no_overlap, clk, rst_n, in_ready, !out_valid)
    `SHA1_ASSERT_SAME(a_round_range, clk, rst_n, state_reg == S_ROUND, round_reg < 7'd80)
    `SHA1_ASSERT_SAME(a_out_aligned, clk, rst_n, out_valid, pos_reg == 6'd0 && fin_pend_reg)
    `SHA1_ASSERT_NEXT(a_restart, clk, rst_n, out_valid && out_ready && last_word, in_ready && h_reg[0] == H_INIT[0] && count_reg == 61'd0)

endmodule

// ===== tb/sv/tb_sha1_hash_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Feeds byte-serial messages through the valid/ready request channel and
// checks every digest word against a SHA-1 computation kept alongside the
// engine. The messages include empty ones, empty requests and lengths around
// the padding boundaries. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine;

    import sha1_pkg::*;

    localparam int QUIET_TAIL = 40;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        bit         settle;
    } byte_req_t;

    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    word_t       digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    byte_req_t    request_q [$];
    digest_word_t digest_q [$];

    word_t       chain [NUM_WORDS];
    logic [7:0]  block_bytes [64];
    logic [60:0] msg_bytes;

    int in_gap = 0;
    int out_gap = 0;
    int fail_count = 0;
    int stim_items = 0;

    sha1_hash_engine u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #5 clk = ~clk;

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function void compress_block();
        word_t sched [16];
        word_t a, b, c, d, e, f, k, sum;
        for (int t = 0; t < 16; t++)
        begin
            sched[t] = {block_bytes[4 * t], block_bytes[4 * t + 1],
                        block_bytes[4 * t + 2], block_bytes[4 * t + 3]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                sched[t % 16] = rotl(sched[(t + 13) % 16] ^ sched[(t + 8) % 16] ^
                                     sched[(t + 2) % 16] ^ sched[t % 16], 1);
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K_1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_3;
            end
            sum = rotl(a, 5) + f + e + k + sched[t % 16];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function void clear_message();
        foreach (chain[i])
            chain[i] = H_INIT[i];
        msg_bytes = '0;
    endfunction

    function void absorb_request(byte_req_t req);
        int pos;
        logic [63:0] bit_len;
        digest_word_t dw;
        if (req.byte_valid)
        begin
            block_bytes[msg_bytes[5:0]] = req.data_byte;
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0)
                compress_block();
        end
        if (!req.end_of_message)
            return;
        pos = int'(msg_bytes[5:0]);
        block_bytes[pos] = PAD_MARK;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        bit_len = {msg_bytes, 3'b000};
        for (int i = 0; i < 8; i++)
            block_bytes[56 + i] = bit_len[63 - 8 * i -: 8];
        compress_block();
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            dw.word  = chain[i];
            dw.index = 3'(i);
            dw.last  = (i == NUM_WORDS - 1);
            digest_q.insert(digest_q.size(), dw);
        end
        clear_message();
    endfunction

    task automatic report_failure(string what);
        if (fail_count < MAX_SHOWN)
            $display("%0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic add_request(logic [7:0] d, logic bv, logic eom, bit settle);
        byte_req_t req;
        req.data_byte      = d;
        req.byte_valid     = bv;
        req.end_of_message = eom;
        req.settle         = settle;
        request_q.insert(request_q.size(), req);
        stim_items++;
    endtask

    task automatic add_message(int len, bit byte_on_end, bit settle);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                add_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            add_request(8'($urandom_range(0, 255)), 1'b1,
                        byte_on_end && (i == len - 1), settle && (i == 0));
        end
        if (!byte_on_end || len == 0)
            add_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, settle && (len == 0));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                absorb_request(request_q[0]);
                void'(request_q.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() == 0 ||
                         (request_q[0].settle && digest_q.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else if (request_q.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
                begin
                    in_gap   <= $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid       <= 1'b1;
                    data_byte      <= request_q[0].data_byte;
                    byte_valid     <= request_q[0].byte_valid;
                    end_of_message <= request_q[0].end_of_message;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        digest_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    report_failure($sformatf("unexpected digest word %h index %0d last %b",
                                             digest_word, word_index, last_word));
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_word !== want.word || word_index !== want.index ||
                        last_word !== want.last)
                    begin
                        report_failure($sformatf(
                            "digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                            want.word, want.index, want.last,
                            digest_word, word_index, last_word));
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (request_q.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
            begin
                out_gap   <= $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int pad_lens [6];
        int n_msgs;
        int sel;
        int len;
        pad_lens = '{55, 56, 57, 63, 64, 65};
        n_msgs = 0;
        clear_message();

        // Empty message, and an empty request before an empty message.
        add_request(8'h00, 1'b0, 1'b1, 1'b0);
        add_request(8'hFF, 1'b0, 1'b0, 1'b0);
        add_request(8'hA5, 1'b0, 1'b1, 1'b0);
        // "abc" with the last byte on the final request, then with a separate end.
        add_request(8'h61, 1'b1, 1'b0, 1'b0);
        add_request(8'h62, 1'b1, 1'b0, 1'b0);
        add_request(8'h63, 1'b1, 1'b1, 1'b0);
        add_request(8'h61, 1'b1, 1'b0, 1'b0);
        add_request(8'h62, 1'b1, 1'b0, 1'b0);
        add_request(8'h63, 1'b1, 1'b0, 1'b0);
        add_request(8'h00, 1'b0, 1'b1, 1'b0);
        // Extreme byte values and an empty request inside a message.
        add_request(8'h00, 1'b1, 1'b1, 1'b0);
        add_request(8'hFF, 1'b1, 1'b0, 1'b0);
        add_request(8'h00, 1'b0, 1'b1, 1'b0);
        add_request(8'h80, 1'b1, 1'b0, 1'b0);
        add_request(8'h55, 1'b0, 1'b0, 1'b0);
        add_request(8'h7F, 1'b1, 1'b1, 1'b0);

        while (stim_items < 200 || n_msgs < 3)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                len = 0;
            else if (sel < 7)
                len = $urandom_range(1, 24);
            else
                len = pad_lens[$urandom_range(0, 5)];
            add_message(len, 1'($urandom_range(0, 1)),
                        n_msgs == 2 || $urandom_range(0, 5) == 0);
            n_msgs++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || digest_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("** sha1_hash_engine: PASSED **");
        else
            $display("** sha1_hash_engine: FAILED **");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("** sha1_hash_engine: FAILED **");
        $finish;
    end

endmodule
